>>> src/mkstq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mkstq_pkg
// Shared types, codes and the key compare for the sorted task queue.
// ---------------------------------------------------------------------------
package mkstq_pkg;

	localparam int DEPTH_DEFAULT = 16;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_STATUS = 2'd2;

	typedef enum logic [1:0] {
		MODE_WAKE = 2'd0,
		MODE_REM  = 2'd1,
		MODE_PRIO = 2'd2,
		MODE_FIFO = 2'd3
	} sort_mode_t;

	typedef struct packed {
		logic [7:0]  id;
		logic [31:0] wake;
		logic [15:0] rem;
		logic [7:0]  prio;
	} task_t;

	typedef struct packed {
		logic       insert_en;
		logic       remove_en;
		sort_mode_t mode;
	} cell_ctrl_t;

	// new record a goes in front of stored record b
	function automatic logic goes_before(sort_mode_t mode, task_t a, task_t b);
		logic res;
		unique case (mode)
			MODE_WAKE: res = a.wake < b.wake;
			MODE_REM:  res = a.rem < b.rem;
			MODE_PRIO: res = a.prio > b.prio;
			MODE_FIFO: res = 1'b0;
		endcase
		return res;
	endfunction

endpackage
`default_nettype wire

>>> src/mkstq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mkstq_cell
// One slot of the queue: compares the new record against its own and
// loads new, left or right neighbor data on insert or remove.
// ---------------------------------------------------------------------------
module mkstq_cell (
	input  wire                     clk,
	input  wire                     arst_n,
	input  mkstq_pkg::cell_ctrl_t   ctrl,
	input  mkstq_pkg::task_t        new_task,
	input  mkstq_pkg::task_t        left_task,
	input  wire                     left_valid,
	input  mkstq_pkg::task_t        right_task,
	input  wire                     right_valid,
	input  wire                     found_in,
	output logic                    found_out,
	output mkstq_pkg::task_t        task_out,
	output logic                    valid_out
);
	import mkstq_pkg::*;

	task_t task_q;
	logic  valid_q;
	task_t task_d;
	logic  valid_d;
	logic  hit;

	assign hit       = !valid_q || goes_before(ctrl.mode, new_task, task_q);
	assign found_out = found_in || hit;

	always_comb begin
		task_d  = task_q;
		valid_d = valid_q;
		if (ctrl.remove_en) begin
			task_d  = right_task;
			valid_d = right_valid;
		end else if (ctrl.insert_en) begin
			if (found_in) begin
				task_d  = left_task;
				valid_d = left_valid;
			end else if (hit) begin
				task_d  = new_task;
				valid_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		task_q <= task_d;
	end

	assign task_out  = task_q;
	assign valid_out = valid_q;

endmodule
`default_nettype wire

>>> src/multi_key_sorted_task_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// the result of an accepted request is registered and presented in the next cycle
// throughput: 1 request per cycle while out_ready is high; every cell compares and shifts in the same cycle
// a new request is taken while the previous result waits, if out_ready is high
// reset clears all cell valid bits (queue empty) and sets sort mode to fifo
// slot payload is not reset; an empty cell is never read out
// ---------------------------------------------------------------------------
// multi_key_sorted_task_queue
// Bounded ordered task queue built as a row of compare-and-shift cells.
// ---------------------------------------------------------------------------
module multi_key_sorted_task_queue #(
	parameter int DEPTH = mkstq_pkg::DEPTH_DEFAULT
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_data,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [1:0]  opcode,
	input  wire  [7:0]  task_id,
	input  wire  [31:0] wake_time,
	input  wire  [15:0] burst_ticks,
	input  wire  [7:0]  task_priority,
	output logic        out_valid,
	input  wire         out_ready,
	output logic        had_task,
	output logic [7:0]  out_task_id,
	output logic [31:0] out_wake_time,
	output logic [15:0] out_burst_ticks,
	output logic [7:0]  out_priority,
	output logic        queue_empty,
	output logic        queue_full,
	output logic        insert_dropped
);
	import mkstq_pkg::*;

	sort_mode_t       sort_mode_q;
	logic             out_valid_q;
	logic             had_task_q;
	task_t            out_task_q;
	logic             queue_empty_q;
	logic             queue_full_q;
	logic             insert_dropped_q;

	logic             in_accept;
	task_t            new_task;
	cell_ctrl_t       ctrl;
	task_t            cell_task [DEPTH];
	logic [DEPTH-1:0] cell_valid;
	logic [DEPTH:0]   found;
	task_t            left_task [DEPTH];
	logic [DEPTH-1:0] left_valid;
	task_t            right_task [DEPTH];
	logic [DEPTH-1:0] right_valid;

	logic             had_d;
	logic             empty_d;
	logic             full_d;
	logic             dropped_d;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_accept = in_valid && in_ready;

	assign new_task = '{id: task_id, wake: wake_time, rem: burst_ticks,
		prio: task_priority};

	assign ctrl.insert_en = in_accept && (opcode == OP_INSERT) && !cell_valid[DEPTH-1];
	assign ctrl.remove_en = in_accept && (opcode == OP_REMOVE);
	assign ctrl.mode      = sort_mode_q;

	assign found[0] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign left_task[i]  = '0;
			assign left_valid[i] = 1'b0;
		end else begin : g_mid
			assign left_task[i]  = cell_task[i-1];
			assign left_valid[i] = cell_valid[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_task[i]  = '0;
			assign right_valid[i] = 1'b0;
		end else begin : g_inner
			assign right_task[i]  = cell_task[i+1];
			assign right_valid[i] = cell_valid[i+1];
		end

		mkstq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.new_task    (new_task),
			.left_task   (left_task[i]),
			.left_valid  (left_valid[i]),
			.right_task  (right_task[i]),
			.right_valid (right_valid[i]),
			.found_in    (found[i]),
			.found_out   (found[i+1]),
			.task_out    (cell_task[i]),
			.valid_out   (cell_valid[i])
		);
	end

	always_comb begin
		had_d     = 1'b0;
		dropped_d = 1'b0;
		unique case (opcode)
			OP_INSERT: begin
				dropped_d = cell_valid[DEPTH-1];
				empty_d   = 1'b0;
				full_d    = cell_valid[DEPTH-2];
			end
			OP_REMOVE: begin
				had_d   = cell_valid[0];
				empty_d = !cell_valid[1];
				full_d  = 1'b0;
			end
			OP_STATUS: begin
				empty_d = !cell_valid[0];
				full_d  = cell_valid[DEPTH-1];
			end
			default: begin
				empty_d = !cell_valid[0];
				full_d  = cell_valid[DEPTH-1];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sort_mode_q <= MODE_FIFO;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				sort_mode_q <= sort_mode_t'(cfg_data);
			end
			if (in_accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			had_task_q       <= had_d;
			out_task_q       <= had_d ? cell_task[0] : '0;
			queue_empty_q    <= empty_d;
			queue_full_q     <= full_d;
			insert_dropped_q <= dropped_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign had_task        = had_task_q;
	assign out_task_id     = out_task_q.id;
	assign out_wake_time   = out_task_q.wake;
	assign out_burst_ticks = out_task_q.rem;
	assign out_priority    = out_task_q.prio;
	assign queue_empty     = queue_empty_q;
	assign queue_full      = queue_full_q;
	assign insert_dropped  = insert_dropped_q;

	// occupied cells stay packed at the head
	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((cell_valid >> 1) & ~cell_valid) == '0)
		else $error("queue cells not contiguous");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (queue_empty_q == !cell_valid[0]))
		else $error("empty flag disagrees with cells");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (queue_full_q == cell_valid[DEPTH-1]))
		else $error("full flag disagrees with cells");

	a_remove_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && (opcode == OP_REMOVE) && cell_valid[0]) |=> had_task_q)
		else $error("remove on non-empty queue returned no task");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && insert_dropped_q) |-> (queue_full_q && !had_task_q))
		else $error("dropped insert without full queue");

endmodule
`default_nettype wire
